// ----- rtl/taapr_pkg.sv -----
// Shared types, constants and helper functions for the two-axis angle position regulator.
`timescale 1ns / 1ps

package taapr_pkg;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_SWING  = 2'd1,
		REQ_ROTATE = 2'd2,
		REQ_STOP   = 2'd3
	} req_t;

	localparam int ANGLE_W     = 13;
	localparam int CODE_W      = 12;
	localparam int CMD_W       = 15;
	localparam int ERR_W       = 15;
	localparam int MAG_W       = 14;
	localparam int TOL_W       = 10;
	localparam int MICRO_W     = 9;
	localparam int GAIN_W      = 8;
	localparam int MAXSPD_W    = 12;
	localparam int P1_W        = 22;
	localparam int P2_W        = 31;
	localparam int SP_W        = P2_W - 4;
	localparam int LIMRAW_W    = 21;
	localparam int LIM_W       = 20;
	localparam int SPEED_W     = 21;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 13;
	localparam int IN_TDATA_W  = 48;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 72;
	localparam int OUT_USED_W  = 70;

	localparam logic [CFG_IDX_W-1:0] CFG_SWING_UP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SWING_DOWN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MICROSTEPS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SWING_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_GAIN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 3'd6;

	localparam logic [ANGLE_W-1:0] HALF_TURN = 13'd2880;
	localparam logic [ANGLE_W-1:0] KEEP_LO   = 13'd1120;
	localparam logic [ANGLE_W-1:0] KEEP_HI   = 13'd2880;
	localparam logic [ANGLE_W-1:0] KEEP_MID  = 13'd2000;

	localparam logic [ERR_W-1:0] TURN_E      = 15'd5760;
	localparam logic signed [ERR_W-1:0] HALF_TURN_S = 15'sd2880;

	// Bias that lifts any 15-bit command to a positive value, a whole number of turns.
	localparam logic [16:0] WRAP_BIAS = 17'd17280;
	localparam logic [15:0] TURN_X1 = 16'd5760;
	localparam logic [15:0] TURN_X2 = 16'd11520;
	localparam logic [15:0] TURN_X3 = 16'd17280;
	localparam logic [15:0] TURN_X4 = 16'd23040;
	localparam logic [15:0] TURN_X5 = 16'd28800;

	localparam logic [P1_W-1:0]  SPEED_OFFSET16 = 22'd3200;
	localparam logic [LIM_W-1:0] FIELD_MAX      = 20'hFFFFF;

	localparam logic [TOL_W-1:0]    TOL_RST    = 10'd16;
	localparam logic [MICRO_W-1:0]  MICRO_RST  = 9'd1;
	localparam logic [GAIN_W-1:0]   SGAIN_RST  = 8'd60;
	localparam logic [GAIN_W-1:0]   RGAIN_RST  = 8'd80;
	localparam logic [MAXSPD_W-1:0] MAXSPD_RST = 12'd4000;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic mul1;
		logic mul2;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic is_tick;
	} dp_status_t;

	// floor(code * 45 / 32)
	function automatic logic [ANGLE_W-1:0] code_to_angle(input logic [CODE_W-1:0] code);
		logic [17:0] prod;
		prod = 18'(code) * 18'd45;
		return prod[17:5];
	endfunction

	function automatic logic [MAG_W-1:0] err_mag(input logic [ERR_W-1:0] e);
		logic [ERR_W-1:0] n;
		n = ~e + 15'd1;
		return e[ERR_W-1] ? n[MAG_W-1:0] : e[MAG_W-1:0];
	endfunction

	function automatic logic [SPEED_W-1:0] speed_out(
		input logic [SP_W-1:0]     sp,
		input logic [LIMRAW_W-1:0] lim,
		input logic                zero,
		input logic                neg
	);
		logic [LIM_W-1:0]   lim_c;
		logic [LIM_W-1:0]   m;
		logic [SPEED_W-1:0] pos;
		lim_c = lim[LIMRAW_W-1] ? FIELD_MAX : lim[LIM_W-1:0];
		m     = (sp > SP_W'(lim_c)) ? lim_c : sp[LIM_W-1:0];
		pos   = {1'b0, m};
		if (zero)
			return '0;
		return neg ? (~pos + 21'd1) : pos;
	endfunction

endpackage

// ----- rtl/taapr_datapath.sv -----
// Datapath: configuration, axis state, error formation, speed multipliers and result register.
`timescale 1ns / 1ps

module taapr_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [taapr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [taapr_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [taapr_pkg::IN_TDATA_W-1:0]      in_data,
	input  logic [taapr_pkg::IN_TUSER_W-1:0]      in_user,
	input  taapr_pkg::dp_cmd_t                    cmd,
	output taapr_pkg::dp_status_t                 status,
	output logic [taapr_pkg::OUT_TDATA_W-1:0]     out_data
);
	import taapr_pkg::*;

	// configuration
	logic [ANGLE_W-1:0]  up_angle_q, down_angle_q;
	logic [TOL_W-1:0]    tol_q;
	logic [MICRO_W-1:0]  micro_q;
	logic [GAIN_W-1:0]   sgain_q, rgain_q;
	logic [MAXSPD_W-1:0] maxspd_q;

	// latched request
	req_t              req_q;
	logic [CMD_W-1:0]  cv_q;
	logic [CODE_W-1:0] scode_q, rcode_q;
	logic              sok_q, rok_q;

	// axis state
	logic [ANGLE_W-1:0] s_target_q, r_target_q, s_angle_q, r_angle_q;
	logic               s_armed_q, r_armed_q;

	// speed pipeline
	logic [MAG_W-1:0]    s_mag_q, r_mag_q;
	logic                s_neg_q, r_neg_q, s_zero_q, r_zero_q;
	logic [P1_W-1:0]     s_p1_q, r_p1_q;
	logic [P2_W-1:0]     s_p2_q, r_p2_q;
	logic [LIMRAW_W-1:0] lim_q;
	logic [OUT_USED_W-1:0] out_q;

	logic [16:0]          wx;
	logic [15:0]          x;
	logic [15:0]          x_red;
	logic [ANGLE_W-1:0]   rot_cmd;
	logic [ANGLE_W-1:0]   s_angle_n, r_angle_n;
	logic signed [ERR_W-1:0] se, re;
	logic [SPEED_W-1:0]   s_speed, r_speed;

	assign status.is_tick = (req_q == REQ_TICK);

	// rotate command: reduce modulo one turn, then snap the keep-out zone to its edges
	always_comb begin
		wx = {{2{cv_q[CMD_W-1]}}, cv_q} + WRAP_BIAS;
		x  = wx[15:0];
		priority if (x >= TURN_X5) begin
			x_red = x - TURN_X5;
		end else if (x >= TURN_X4) begin
			x_red = x - TURN_X4;
		end else if (x >= TURN_X3) begin
			x_red = x - TURN_X3;
		end else if (x >= TURN_X2) begin
			x_red = x - TURN_X2;
		end else if (x >= TURN_X1) begin
			x_red = x - TURN_X1;
		end else begin
			x_red = x;
		end
		rot_cmd = x_red[ANGLE_W-1:0];
		if (rot_cmd > KEEP_LO && rot_cmd < KEEP_HI) begin
			rot_cmd = (rot_cmd < KEEP_MID) ? KEEP_LO : KEEP_HI;
		end
	end

	// tick: new angles and wrapped errors
	always_comb begin
		s_angle_n = sok_q ? code_to_angle(scode_q) : s_angle_q;
		r_angle_n = rok_q ? code_to_angle(rcode_q) : r_angle_q;

		se = $signed({2'b00, s_target_q}) - $signed({2'b00, s_angle_n});
		if (s_target_q == up_angle_q && s_angle_n < HALF_TURN) begin
			se = se - $signed(TURN_E);
		end else if (s_target_q == down_angle_q && s_angle_n > HALF_TURN) begin
			se = se + $signed(TURN_E);
		end

		re = $signed({2'b00, r_target_q}) - $signed({2'b00, r_angle_n});
		if (re > HALF_TURN_S) begin
			re = re - $signed(TURN_E);
		end
		if (re < -HALF_TURN_S) begin
			re = re + $signed(TURN_E);
		end
	end

	always_comb begin
		s_speed = speed_out(s_p2_q[P2_W-1:4], lim_q, s_zero_q, s_neg_q);
		r_speed = speed_out(r_p2_q[P2_W-1:4], lim_q, r_zero_q, r_neg_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_angle_q   <= '0;
			down_angle_q <= '0;
			tol_q        <= TOL_RST;
			micro_q      <= MICRO_RST;
			sgain_q      <= SGAIN_RST;
			rgain_q      <= RGAIN_RST;
			maxspd_q     <= MAXSPD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SWING_UP:   up_angle_q   <= cfg_data[ANGLE_W-1:0];
				CFG_SWING_DOWN: down_angle_q <= cfg_data[ANGLE_W-1:0];
				CFG_TOLERANCE:  tol_q        <= cfg_data[TOL_W-1:0];
				CFG_MICROSTEPS: micro_q      <= cfg_data[MICRO_W-1:0];
				CFG_SWING_GAIN: sgain_q      <= cfg_data[GAIN_W-1:0];
				CFG_ROT_GAIN:   rgain_q      <= cfg_data[GAIN_W-1:0];
				CFG_MAX_SPEED:  maxspd_q     <= cfg_data[MAXSPD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= REQ_TICK;
		end else if (cmd.load_in) begin
			req_q <= req_t'(in_user);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cv_q    <= in_data[14:0];
			scode_q <= in_data[26:15];
			sok_q   <= in_data[27];
			rcode_q <= in_data[39:28];
			rok_q   <= in_data[40];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_target_q <= '0;
			r_target_q <= '0;
			s_angle_q  <= '0;
			r_angle_q  <= '0;
			s_armed_q  <= 1'b0;
			r_armed_q  <= 1'b0;
		end else if (cmd.exec) begin
			unique case (req_q)
				REQ_SWING: begin
					if (cv_q == 15'd1) begin
						s_target_q <= up_angle_q;
						s_armed_q  <= 1'b1;
					end else if (cv_q == 15'd0) begin
						s_target_q <= down_angle_q;
						s_armed_q  <= 1'b1;
					end
				end
				REQ_ROTATE: begin
					r_target_q <= rot_cmd;
					r_armed_q  <= 1'b1;
				end
				REQ_STOP: begin
					s_armed_q  <= 1'b0;
					r_target_q <= r_angle_q;
					r_armed_q  <= 1'b1;
				end
				REQ_TICK: begin
					s_angle_q <= s_angle_n;
					r_angle_q <= r_angle_n;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			s_mag_q  <= err_mag(se);
			r_mag_q  <= err_mag(re);
			s_neg_q  <= se < 0;
			r_neg_q  <= re > 0;
			s_zero_q <= !s_armed_q || (err_mag(se) <= MAG_W'(tol_q));
			r_zero_q <= !r_armed_q || (err_mag(re) <= MAG_W'(tol_q));
		end
		if (cmd.mul1) begin
			s_p1_q <= P1_W'(s_mag_q) * P1_W'(sgain_q) + SPEED_OFFSET16;
			r_p1_q <= P1_W'(r_mag_q) * P1_W'(rgain_q) + SPEED_OFFSET16;
			lim_q  <= LIMRAW_W'(maxspd_q) * LIMRAW_W'(micro_q);
		end
		if (cmd.mul2) begin
			s_p2_q <= P2_W'(s_p1_q) * P2_W'(micro_q);
			r_p2_q <= P2_W'(r_p1_q) * P2_W'(micro_q);
		end
		if (cmd.load_out) begin
			out_q <= {r_angle_q, s_angle_q, r_armed_q, r_speed, s_armed_q, s_speed};
		end
	end

	assign out_data = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_q};

endmodule

// ----- rtl/taapr_ctrl.sv -----
// Controller: sequences each request through the datapath and owns the result handshake.
`timescale 1ns / 1ps

module taapr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_valid,
	output logic                   s_ready,
	output logic                   m_valid,
	input  logic                   m_ready,
	input  taapr_pkg::dp_status_t  status,
	output taapr_pkg::dp_cmd_t     cmd
);
	import taapr_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_MUL1 = 5'b00100,
		ST_MUL2 = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q, state_n;
	logic   m_valid_q;
	logic   can_load;

	assign can_load = !m_valid_q || m_ready;
	assign m_valid  = m_valid_q;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		s_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.load_in = 1'b1;
					state_n     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_n  = status.is_tick ? ST_MUL1 : ST_IDLE;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_n  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_n  = ST_OUT;
			end
			ST_OUT: begin
				// hold until the result register is free
				if (can_load) begin
					cmd.load_out = 1'b1;
					s_ready      = 1'b1;
					if (s_valid) begin
						cmd.load_in = 1'b1;
						state_n     = ST_EXEC;
					end else begin
						state_n = ST_IDLE;
					end
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/two_axis_angle_position_regulator.sv -----
// Top level of the two-axis angle position regulator: ports, controller and datapath.
`timescale 1ns / 1ps
//
//  Channel   Dir  Beat moves                         Result
//  --------  ---  ---------------------------------  ------------------------------
//  s_axis    in   one request (tick/swing/rotate/stop) none, or one result on a tick
//  m_axis    out  one result beat per tick            speeds, run flags, angles
//  cfg       in   one register write (index, data)   updates a regulator setting
//
//  A command (swing, rotate, stop) is accepted, then updates the axis state.
//  A tick is accepted, then runs angle/error update, gain multiply and microstep
//  multiply; the result is loaded as the next request is accepted. The two
//  chained multiplies of the speed law make a tick the longer request.
//  A result beat waits in the output register; the block still accepts the next
//  request and only the next tick stalls if that beat has not been taken.
//  arst_n clears all axis state and loads the documented register defaults.
//  Write cfg only while no request is in flight; cfg_ready is always high.

module two_axis_angle_position_regulator (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [14:0] command_value, [26:15] swing_code, [27] swing_code_ok,
	// [39:28] rotate_code, [40] rotate_code_ok, [47:41] zero
	input  logic [47:0] s_axis_tdata,
	// [1:0] req_type
	input  logic [1:0]  s_axis_tuser,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [20:0] swing_speed, [21] swing_run, [42:22] rotate_speed, [43] rotate_run,
	// [56:44] swing_angle_now, [69:57] rotate_angle_now, [71:70] zero
	output logic [71:0] m_axis_tdata,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	import taapr_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Registers take every write at once.
	assign cfg_ready = 1'b1;

	taapr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.status  (status),
		.cmd     (cmd)
	);

	// Datapath holds settings, axis state, the per-axis speed pipelines and the result beat.
	taapr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.cmd       (cmd),
		.status    (status),
		.out_data  (m_axis_tdata)
	);

endmodule

// ----- tb/two_axis_angle_position_regulator_tb.sv -----
// Self-checking testbench for the two-axis angle position regulator.
`timescale 1ns / 1ps

module two_axis_angle_position_regulator_tb;

	import taapr_pkg::*;

	// Geometry in 1/16 degree, kept under local names.
	localparam int FULL_REV   = 5760;
	localparam int HALF_REV   = 2880;
	localparam int ZONE_LO    = 1120;
	localparam int ZONE_HI    = 2880;
	localparam int ZONE_SPLIT = 2000;
	localparam int BASE_RATE  = 3200;     // 200 steps/s, times 16
	localparam longint RATE_CAP = 1048575;

	localparam int NUM_PHASES      = 8;   // phase 0 is directed
	localparam int ITEMS_PER_PHASE = 250;
	localparam int RX_HOLD_CYCLES  = 400;
	localparam int SETTLE_CYCLES   = 16;
	localparam int LIMIT_CYCLES    = 400000;

	typedef struct packed {
		req_t              kind;
		logic signed [14:0] cmd;
		logic [11:0]       s_code;
		logic              s_ok;
		logic [11:0]       r_code;
		logic              r_ok;
	} regulator_req_t;

	typedef struct packed {
		logic [20:0] s_speed;
		logic        s_run;
		logic [20:0] r_speed;
		logic        r_run;
		logic [12:0] s_angle;
		logic [12:0] r_angle;
	} regulator_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;

	two_axis_angle_position_regulator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Register settings per phase, in the order of reg_order:
	// up preset, down preset, tolerance, microsteps, swing gain, rotate gain, max speed.
	logic [2:0] reg_order [7] = '{CFG_SWING_UP, CFG_SWING_DOWN, CFG_TOLERANCE,
		CFG_MICROSTEPS, CFG_SWING_GAIN, CFG_ROT_GAIN, CFG_MAX_SPEED};
	int phase_regs [NUM_PHASES][7] = '{
		'{4000, 1000,   16,  16,  60,  80, 4000},
		'{1440, 4320,   16,   1,  60,  80, 4000},
		'{5759,    0,    0, 256, 255, 255, 4000},  // highest gains, zero tolerance
		'{   0, 5759, 1023,   1,   0,   0,    1},  // zero gains, widest tolerance, lowest limit
		'{2880, 2880,  100,   8, 128, 200, 2000},  // equal presets
		'{ 300, 5000,   40, 511, 170,  85, 4095},  // limit beyond the speed field
		'{2000, 3500,    8,   0,  90,  90, 3000},  // zero microsteps
		'{5000, 2879,   64,  32, 255,   1, 4000}
	};

	// Shadow of the block: registers (reset values) and axis state.
	int cfg_shadow [8] = '{0, 0, 16, 1, 60, 80, 4000, 0};
	int  swing_tgt = 0, rotate_tgt = 0, swing_ang = 0, rotate_ang = 0;
	bit  swing_armed = 1'b0, rotate_armed = 1'b0;

	regulator_req_t pending_reqs [$];
	regulator_out_t predicted_outputs [$];

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          rx_hold_trig = 1'b0;
	bit          rx_hold_seen = 1'b0;
	int          rx_hold_left = 0;
	int          mismatch_count = 0;
	int          results_seen = 0;
	int unsigned cycle_count = 0;
	bit          drv_busy;
	regulator_out_t mon_got, mon_want;

	task automatic log_mismatch(input string msg);
		mismatch_count++;
		$display("MISMATCH result %0d: %s", results_seen, msg);
	endtask

	// Proportional rate for one axis, microstep scaled and saturated.
	function automatic longint step_rate(input longint err, input longint gain);
		longint mag, rate, cap;
		mag = (err < 0) ? -err : err;
		if (mag <= cfg_shadow[CFG_TOLERANCE])
			return 0;
		rate = ((mag * gain + BASE_RATE) * cfg_shadow[CFG_MICROSTEPS]) >>> 4;
		cap  = longint'(cfg_shadow[CFG_MAX_SPEED]) * cfg_shadow[CFG_MICROSTEPS];
		if (cap > RATE_CAP)
			cap = RATE_CAP;
		if (rate > cap)
			rate = cap;
		return (err < 0) ? -rate : rate;
	endfunction

	// Advance the shadow state by one accepted request; a tick yields one result.
	function automatic void predict_regulator(input regulator_req_t r);
		int cmd_val, a;
		longint se, re, ss, rs;
		regulator_out_t o;
		cmd_val = int'(r.cmd);
		ss = 0;
		rs = 0;
		unique case (r.kind)
			REQ_SWING: begin
				if (cmd_val == 1) begin
					swing_tgt = cfg_shadow[CFG_SWING_UP];
					swing_armed = 1'b1;
				end else if (cmd_val == 0) begin
					swing_tgt = cfg_shadow[CFG_SWING_DOWN];
					swing_armed = 1'b1;
				end
			end
			REQ_ROTATE: begin
				a = cmd_val % FULL_REV;
				if (a < 0)
					a += FULL_REV;
				// Snap the keep-out zone to its nearer edge.
				if (a > ZONE_LO && a < ZONE_HI)
					a = (a < ZONE_SPLIT) ? ZONE_LO : ZONE_HI;
				rotate_tgt = a;
				rotate_armed = 1'b1;
			end
			REQ_STOP: begin
				swing_armed = 1'b0;
				rotate_tgt = rotate_ang;
				rotate_armed = 1'b1;
			end
			default: begin
				if (r.s_ok)
					swing_ang = (int'(r.s_code) * 45) >> 5;
				if (r.r_ok)
					rotate_ang = (int'(r.r_code) * 45) >> 5;
				if (swing_armed) begin
					se = swing_tgt - swing_ang;
					if (swing_tgt == cfg_shadow[CFG_SWING_UP] && swing_ang < HALF_REV)
						se -= FULL_REV;
					else if (swing_tgt == cfg_shadow[CFG_SWING_DOWN] && swing_ang > HALF_REV)
						se += FULL_REV;
					ss = step_rate(se, cfg_shadow[CFG_SWING_GAIN]);
				end
				if (rotate_armed) begin
					re = rotate_tgt - rotate_ang;
					if (re > HALF_REV)
						re -= FULL_REV;
					if (re < -HALF_REV)
						re += FULL_REV;
					rs = -step_rate(re, cfg_shadow[CFG_ROT_GAIN]);
				end
				o.s_speed = ss[20:0];
				o.s_run   = swing_armed;
				o.r_speed = rs[20:0];
				o.r_run   = rotate_armed;
				o.s_angle = 13'(swing_ang);
				o.r_angle = 13'(rotate_ang);
				predicted_outputs.push_back(o);
			end
		endcase
	endfunction

	// Driver: retire the accepted beat into the predictor, then hold or offer the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_regulator(pending_reqs.pop_front());
			// A beat on offer stays until taken.
			drv_busy = s_axis_tvalid && !s_axis_tready;
			if (!drv_busy) begin
				if (pending_reqs.size() != 0 &&
					int'($urandom_range(99)) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {7'd0, pending_reqs[0].r_ok, pending_reqs[0].r_code,
						pending_reqs[0].s_ok, pending_reqs[0].s_code, pending_reqs[0].cmd};
					s_axis_tuser  <= pending_reqs[0].kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here so the monitor only sees whether it is active.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold_left <= 0;
			rx_hold_seen <= 1'b0;
		end else if (rx_hold_trig != rx_hold_seen) begin
			rx_hold_seen <= rx_hold_trig;
			rx_hold_left <= RX_HOLD_CYCLES;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end
	end

	// Monitor: compare each result beat with the oldest prediction, field by field.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				mon_got.s_speed = m_axis_tdata[20:0];
				mon_got.s_run   = m_axis_tdata[21];
				mon_got.r_speed = m_axis_tdata[42:22];
				mon_got.r_run   = m_axis_tdata[43];
				mon_got.s_angle = m_axis_tdata[56:44];
				mon_got.r_angle = m_axis_tdata[69:57];
				if (predicted_outputs.size() == 0) begin
					log_mismatch("result beat with no prediction pending");
				end else begin
					mon_want = predicted_outputs.pop_front();
					if (mon_got.s_speed !== mon_want.s_speed)
						log_mismatch($sformatf("swing_speed %0d, want %0d",
							$signed(mon_got.s_speed), $signed(mon_want.s_speed)));
					if (mon_got.s_run !== mon_want.s_run)
						log_mismatch($sformatf("swing_run %0b, want %0b",
							mon_got.s_run, mon_want.s_run));
					if (mon_got.r_speed !== mon_want.r_speed)
						log_mismatch($sformatf("rotate_speed %0d, want %0d",
							$signed(mon_got.r_speed), $signed(mon_want.r_speed)));
					if (mon_got.r_run !== mon_want.r_run)
						log_mismatch($sformatf("rotate_run %0b, want %0b",
							mon_got.r_run, mon_want.r_run));
					if (mon_got.s_angle !== mon_want.s_angle)
						log_mismatch($sformatf("swing_angle_now %0d, want %0d",
							mon_got.s_angle, mon_want.s_angle));
					if (mon_got.r_angle !== mon_want.r_angle)
						log_mismatch($sformatf("rotate_angle_now %0d, want %0d",
							mon_got.r_angle, mon_want.r_angle));
				end
				results_seen++;
			end
			m_axis_tready <= (rx_hold_left == 0) &&
				(int'($urandom_range(99)) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic queue_item(input req_t kind, input int cmd, input int s_code,
		input bit s_ok, input int r_code, input bit r_ok);
		regulator_req_t r;
		r.kind   = kind;
		r.cmd    = 15'(cmd);
		r.s_code = 12'(s_code);
		r.s_ok   = s_ok;
		r.r_code = 12'(r_code);
		r.r_ok   = r_ok;
		pending_reqs.push_back(r);
	endtask

	// Ticks mixed with commands; tick codes often land near the chosen targets,
	// so the tolerance band and both signs of error are visited often.
	task automatic queue_random(input int count);
		int pick, cmd, s_code, r_code, swing_aim, rotate_aim;
		swing_aim  = int'($urandom_range(5759));
		rotate_aim = int'($urandom_range(5759));
		repeat (count) begin
			pick = int'($urandom_range(99));
			cmd  = int'($urandom);
			if (pick < 55) begin
				s_code = (int'($urandom_range(2)) == 0) ? int'($urandom) :
					(swing_aim * 32) / 45 + int'($urandom_range(40)) - 20;
				r_code = (int'($urandom_range(2)) == 0) ? int'($urandom) :
					(rotate_aim * 32) / 45 + int'($urandom_range(40)) - 20;
				if (int'($urandom_range(19)) == 0)
					s_code = int'($urandom_range(1)) * 4095;
				if (int'($urandom_range(19)) == 0)
					r_code = int'($urandom_range(1)) * 4095;
				queue_item(REQ_TICK, cmd, s_code, int'($urandom_range(9)) != 0,
					r_code, int'($urandom_range(9)) != 0);
			end else if (pick < 70) begin
				if (int'($urandom_range(99)) < 85)
					cmd = int'($urandom_range(1));
				if (cmd == 1)
					swing_aim = cfg_shadow[CFG_SWING_UP];
				else if (cmd == 0)
					swing_aim = cfg_shadow[CFG_SWING_DOWN];
				queue_item(REQ_SWING, cmd, int'($urandom), 1'($urandom_range(1)),
					int'($urandom), 1'($urandom_range(1)));
			end else if (pick < 90) begin
				pick = int'($urandom_range(99));
				if (pick < 60)
					cmd = int'($urandom_range(17279)) - 5760;
				else if (pick < 85)
					cmd = int'($urandom_range(2900, 1100));
				rotate_aim = ((int'(15'(cmd)) % FULL_REV) + FULL_REV) % FULL_REV;
				queue_item(REQ_ROTATE, cmd, int'($urandom), 1'($urandom_range(1)),
					int'($urandom), 1'($urandom_range(1)));
			end else begin
				queue_item(REQ_STOP, cmd, int'($urandom), 1'($urandom_range(1)),
					int'($urandom), 1'($urandom_range(1)));
			end
		end
	endtask

	// Write every register in one burst; cfg_valid stays high across the whole burst.
	task automatic program_regs(input int p);
		cfg_valid <= 1'b1;
		foreach (reg_order[k]) begin
			cfg_index <= reg_order[k];
			cfg_data  <= 13'(phase_regs[p][k]);
			do @(posedge clk); while (!cfg_ready);
			cfg_shadow[reg_order[k]] = phase_regs[p][k];
		end
		cfg_valid <= 1'b0;
	endtask

	// Hold until every request is taken and every result has arrived, then let
	// a trailing command finish inside the block.
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || s_axis_tvalid || predicted_outputs.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int p;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_regs(0);
		// Directed: disarmed ticks, both presets, ignored swing values, wrap at
		// both ends of the command range, each keep-out edge, stop, code extremes.
		queue_item(REQ_TICK,   0,      0,    1, 0,    1);
		queue_item(REQ_SWING,  1,      0,    0, 0,    0);
		queue_item(REQ_TICK,   0,      4095, 1, 4095, 1);
		queue_item(REQ_SWING,  0,      0,    0, 0,    0);
		queue_item(REQ_TICK,   0,      1000, 1, 0,    0);
		queue_item(REQ_SWING,  5,      0,    0, 0,    0);
		queue_item(REQ_SWING,  -1,     0,    0, 0,    0);
		queue_item(REQ_ROTATE, -5760,  0,    0, 0,    0);
		queue_item(REQ_TICK,   0,      0,    0, 2048, 1);
		queue_item(REQ_ROTATE, 11519,  0,    0, 0,    0);
		queue_item(REQ_ROTATE, 1121,   0,    0, 0,    0);
		queue_item(REQ_ROTATE, 1999,   0,    0, 0,    0);
		queue_item(REQ_ROTATE, 2000,   0,    0, 0,    0);
		queue_item(REQ_ROTATE, 2879,   0,    0, 0,    0);
		queue_item(REQ_TICK,   0,      3000, 1, 2048, 1);
		queue_item(REQ_ROTATE, 1120,   0,    0, 0,    0);
		queue_item(REQ_TICK,   0,      2000, 0, 800,  1);
		queue_item(REQ_ROTATE, -16384, 0,    0, 0,    0);
		queue_item(REQ_ROTATE, 16383,  0,    0, 0,    0);
		queue_item(REQ_STOP,   0,      0,    0, 0,    0);
		queue_item(REQ_TICK,   0,      1365, 1, 1365, 1);
		queue_item(REQ_TICK,   0,      2730, 1, 2730, 1);
		queue_item(REQ_SWING,  1,      0,    0, 0,    0);
		queue_item(REQ_TICK,   0,      0,    1, 3000, 1);
		wait_idle();

		for (p = 1; p < NUM_PHASES; p++) begin
			program_regs(p);
			unique case (p % 4)
				1: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct  <= 61;
					recv_stall_pct <= 0;
				end
				3: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 61;
				end
				default: begin
					send_idle_pct  <= 20;
					recv_stall_pct <= 20;
				end
			endcase
			queue_random(ITEMS_PER_PHASE / 2);
			// Back-pressure: stall the receiver long enough that the input stalls too.
			if (p == 1)
				rx_hold_trig <= ~rx_hold_trig;
			// Sender pauses here until every pending result has come back.
			wait_idle();
			queue_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
